// ===== src/skf_pkg.sv =====
// skf_pkg: shared constants, register indexes and controller/datapath
// command and status structs for the scalar Kalman filter. No dependencies.
package skf_pkg;

   localparam int FRAC_BITS_DEFAULT = 16;
   localparam int DATA_W            = 32;
   localparam int CFG_W             = 31;

   localparam logic [CFG_W-1:0] PROCESS_NOISE_RESET     = 31'd655;
   localparam logic [CFG_W-1:0] MEASUREMENT_NOISE_RESET = 31'd6554;

   localparam logic REG_PROCESS_NOISE     = 1'b0;
   localparam logic REG_MEASUREMENT_NOISE = 1'b1;

   localparam logic OP_MEASURE = 1'b0;
   localparam logic OP_REINIT  = 1'b1;

   typedef struct packed {
      logic capture;
      logic reinit;
      logic prep;
      logic div_step;
      logic mul_step;
      logic upd_est;
      logic mul_var;
      logic upd_var;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic op_reinit;
      logic div_done;
   } sts_type;

endpackage

// ===== src/scalar_kalman_filter_top.sv =====
// Channel | Direction | Contents
// req_    | in        | tdata: sample_value[31:0]; tuser: operation
// rsp_    | out       | tdata: filtered_estimate[31:0]
// csr_    | in        | write: index 0 process_noise, 1 measurement_noise
//
// A measurement runs prep, the restoring divider for the gain, then the
// multiplies and updates, one quotient bit per cycle; values are Q16.16 by default.
// A reinitialize skips the divider. One word is in flight at a time; req_tready
// is high only when the sequencer is idle. A stalled result holds in the
// output register; the next word may be accepted meanwhile.
// Synchronous active-high reset; estimate 0, variance 1.0, noise defaults.
module scalar_kalman_filter_top #(
   parameter int FRAC_BITS = skf_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [skf_pkg::DATA_W-1:0]  req_tdata,   // [31:0] sample_value
   input  logic                        req_tuser,   // [0] operation
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [skf_pkg::DATA_W-1:0]  rsp_tdata,   // [31:0] filtered_estimate
   input  logic                        csr_we,
   input  logic                        csr_index,
   input  logic [skf_pkg::CFG_W-1:0]   csr_wdata
);

   skf_pkg::cmd_type cmd;
   skf_pkg::sts_type sts;

   skf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   skf_dpath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .sample    (req_tdata),
      .op        (req_tuser),
      .cmd       (cmd),
      .sts       (sts),
      .result    (rsp_tdata)
   );

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("word accepted while another is in flight");

   a_out_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_tvalid || rsp_tready))
      else $error("output register overwritten while full");

   a_div_then_mul: assert property (@(posedge clock) disable iff (reset)
      (cmd.div_step && sts.div_done) |=> cmd.mul_step)
      else $error("multiply did not follow last divider step");

   a_rsp_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(cmd.out_load))
      else $error("result valid without output load");

endmodule

// ===== src/skf_ctrl.sv =====
// skf_ctrl: sequencer for one word at a time; drives datapath commands
// and the stream handshakes. Depends on skf_pkg.
module skf_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  skf_pkg::sts_type sts,
   output skf_pkg::cmd_type cmd
);

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_PREP     = 3'd1;
   localparam logic [2:0] ST_DIV      = 3'd2;
   localparam logic [2:0] ST_MUL_STEP = 3'd3;
   localparam logic [2:0] ST_UPD_EST  = 3'd4;
   localparam logic [2:0] ST_MUL_VAR  = 3'd5;
   localparam logic [2:0] ST_UPD_VAR  = 3'd6;
   localparam logic [2:0] ST_OUT      = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_PREP;
            end
         end
         ST_PREP: begin
            if (sts.op_reinit) begin
               cmd.reinit = 1'b1;
               state_in   = ST_OUT;
            end else begin
               cmd.prep = 1'b1;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_done) begin
               state_in = ST_MUL_STEP;
            end
         end
         ST_MUL_STEP: begin
            cmd.mul_step = 1'b1;
            state_in     = ST_UPD_EST;
         end
         ST_UPD_EST: begin
            cmd.upd_est = 1'b1;
            state_in    = ST_MUL_VAR;
         end
         ST_MUL_VAR: begin
            cmd.mul_var = 1'b1;
            state_in    = ST_UPD_VAR;
         end
         ST_UPD_VAR: begin
            cmd.upd_var = 1'b1;
            state_in    = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== src/skf_dpath.sv =====
// skf_dpath: config registers, filter state, restoring gain divider,
// shared multiplier and output register. Depends on skf_pkg.
module skf_dpath #(
   parameter int FRAC_BITS = skf_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic                            csr_index,
   input  logic [skf_pkg::CFG_W-1:0]       csr_wdata,
   input  logic [skf_pkg::DATA_W-1:0]      sample,
   input  logic                            op,
   input  skf_pkg::cmd_type                cmd,
   output skf_pkg::sts_type                sts,
   output logic [skf_pkg::DATA_W-1:0]      result
);

   localparam int GW = FRAC_BITS + 1;
   localparam int CW = $clog2(FRAC_BITS + 1);
   localparam int PW = 33 + GW;
   localparam logic [GW-1:0] ONE_G  = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [31:0]   ONE_V  = 32'(ONE_G);
   localparam logic [PW-1:0] HALF_P = PW'(ONE_G) >> 1;

   logic [30:0]   pn_ff, mn_ff;
   logic [31:0]   est_ff, var_ff, samp_ff, p1_ff, out_ff;
   logic          op_ff, neg_ff;
   logic [32:0]   den_ff, mag_ff;
   logic [33:0]   rem_ff;
   logic [GW-1:0] q_ff;
   logic [CW-1:0] cnt_ff;
   logic [PW-1:0] prod_ff;

   logic [32:0]   p1_sum, den_sum, err, mag;
   logic [31:0]   p1_sat;
   logic [33:0]   den34, rem_in;
   logic          ge, den_zero, div_done;
   logic [GW-1:0] q_in, mul_b;
   logic [32:0]   mul_a;
   logic [PW-1:0] prod_in, rnd;
   logic [32:0]   r33;
   logic [33:0]   step34;
   logic [34:0]   sum35;
   logic [31:0]   est_new;

   assign p1_sum  = {1'b0, var_ff} + {2'b00, pn_ff};
   assign p1_sat  = p1_sum[32] ? '1 : p1_sum[31:0];
   assign den_sum = {1'b0, p1_sat} + {2'b00, mn_ff};
   assign err     = {samp_ff[31], samp_ff} - {est_ff[31], est_ff};
   assign mag     = err[32] ? (33'd0 - err) : err;

   // one quotient bit per cycle, integer bit first
   assign den34    = {1'b0, den_ff};
   assign ge       = (rem_ff >= den34);
   assign rem_in   = ge ? ((rem_ff - den34) << 1) : (rem_ff << 1);
   assign den_zero = (den_ff == '0);
   assign div_done = (cnt_ff == CW'(FRAC_BITS));
   always_comb begin
      if (div_done && den_zero) begin
         q_in = ONE_G;
      end else begin
         q_in = {q_ff[GW-2:0], ge};
      end
   end

   assign mul_a   = cmd.mul_var ? {1'b0, p1_ff} : mag_ff;
   assign mul_b   = cmd.mul_var ? (ONE_G - q_ff) : q_ff;
   assign prod_in = {{GW{1'b0}}, mul_a} * {{33{1'b0}}, mul_b};

   assign rnd    = prod_ff + HALF_P;
   assign r33    = rnd[FRAC_BITS +: 33];
   assign step34 = neg_ff ? (34'd0 - {1'b0, r33}) : {1'b0, r33};
   assign sum35  = {{3{est_ff[31]}}, est_ff} + {step34[33], step34};
   always_comb begin
      if (sum35[34:31] == 4'b0000 || sum35[34:31] == 4'b1111) begin
         est_new = sum35[31:0];
      end else if (sum35[34]) begin
         est_new = 32'h8000_0000;
      end else begin
         est_new = 32'h7FFF_FFFF;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pn_ff  <= skf_pkg::PROCESS_NOISE_RESET;
         mn_ff  <= skf_pkg::MEASUREMENT_NOISE_RESET;
         est_ff <= '0;
         var_ff <= ONE_V;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               skf_pkg::REG_PROCESS_NOISE:     pn_ff <= csr_wdata;
               skf_pkg::REG_MEASUREMENT_NOISE: mn_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
         if (cmd.reinit) begin
            est_ff <= samp_ff;
            var_ff <= ONE_V;
         end
         if (cmd.upd_est) begin
            est_ff <= est_new;
         end
         if (cmd.upd_var) begin
            var_ff <= rnd[FRAC_BITS +: 32];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         samp_ff <= sample;
         op_ff   <= op;
      end
      if (cmd.prep) begin
         p1_ff  <= p1_sat;
         den_ff <= den_sum;
         mag_ff <= mag;
         neg_ff <= err[32];
         rem_ff <= {2'b00, p1_sat};
         q_ff   <= '0;
         cnt_ff <= '0;
      end
      if (cmd.div_step) begin
         rem_ff <= rem_in;
         q_ff   <= q_in;
         cnt_ff <= cnt_ff + CW'(1);
      end
      if (cmd.mul_step || cmd.mul_var) begin
         prod_ff <= prod_in;
      end
      if (cmd.out_load) begin
         out_ff <= est_ff;
      end
   end

   assign sts.op_reinit = (op_ff == skf_pkg::OP_REINIT);
   assign sts.div_done  = div_done;
   assign result        = out_ff;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// tb_top: self-checking testbench for scalar_kalman_filter_top, directed table plus random
// phases over several noise settings, with random idling on both streams.
// Depends on skf_pkg and the scalar_kalman_filter_top RTL.
module tb_top;

   localparam int          FRAC       = skf_pkg::FRAC_BITS_DEFAULT;
   localparam longint      ONE        = 64'd1 << FRAC;
   localparam longint      HALF       = 64'd1 << (FRAC - 1);
   localparam int          CYCLE_CAP  = 2000000;
   localparam int          PHASES     = 7;
   localparam int          PHASE_LEN  = 170;
   localparam int          LONG_HOLD  = 400;
   localparam int          DIR_ROWS   = 29;
   localparam logic [30:0] NOISE_MAX  = 31'h7FFF_FFFF;

   typedef enum logic {ROW_WORD, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type kind;
      logic         sel;          // operation, or register index
      logic [31:0]  value;
      logic         known;
      logic [31:0]  known_value;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // [31:0] sample_value
   logic        req_tuser;   // [0] operation
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;   // [31:0] filtered_estimate
   logic        csr_we;
   logic        csr_index;
   logic [30:0] csr_wdata;

   // filter state as the block should hold it
   logic [31:0] est_q;
   logic [31:0] var_q;
   logic [30:0] pn_q;
   logic [30:0] mn_q;

   logic [31:0] pending_estimates[$];
   int          mismatches;
   int          results_seen;
   int          cycles;
   bit          burst_mode;

   stim_row_type dir_rows [DIR_ROWS];

   scalar_kalman_filter_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic [31:0] advance_estimate(input logic op, input logic [31:0] sample);
      longint unsigned p1;
      longint unsigned den;
      longint unsigned gain;
      longint unsigned mag;
      longint unsigned r;
      longint          err;
      longint          step;
      longint          sum;
      if (op == skf_pkg::OP_REINIT) begin
         est_q = sample;
         var_q = 32'(ONE);
      end else begin
         p1 = 64'(var_q) + 64'(pn_q);
         if (p1 > 64'hFFFF_FFFF) p1 = 64'hFFFF_FFFF;
         den = p1 + 64'(mn_q);
         if (den == 0) gain = ONE;
         else gain = (p1 << FRAC) / den;
         err = longint'($signed(sample)) - longint'($signed(est_q));
         if (err < 0) mag = -err;
         else mag = err;
         r = (mag * gain + HALF) >> FRAC;
         step = (err < 0) ? -$signed(r) : $signed(r);
         sum = longint'($signed(est_q)) + step;
         if (sum > 64'sh7FFF_FFFF) est_q = 32'h7FFF_FFFF;
         else if (sum < -64'sh8000_0000) est_q = 32'h8000_0000;
         else est_q = sum[31:0];
         var_q = 32'((p1 * (ONE - gain) + HALF) >> FRAC);
      end
      return est_q;
   endfunction

   // mostly short gaps, a few long ones
   function automatic int idle_cycles();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 16);
      return $urandom_range(30, 100);
   endfunction

   task automatic send_word(input logic op, input logic [31:0] sample,
                            input logic known, input logic [31:0] known_value);
      int          gap;
      logic [31:0] model;
      gap = burst_mode ? 0 : idle_cycles();
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= sample;
      req_tuser  <= op;
      do @(posedge clock); while (!req_tready);
      model = advance_estimate(op, sample);
      pending_estimates.push_back(known ? known_value : model);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_estimates.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [30:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == skf_pkg::REG_PROCESS_NOISE) pn_q = val;
      else mn_q = val;
   endtask

   // result check
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (pending_estimates.size() == 0) begin
            $display("%0t: unexpected estimate, expected none, actual %h", $time, rsp_tdata);
            mismatches++;
         end else if (rsp_tdata !== pending_estimates[0]) begin
            $display("%0t: estimate mismatch, expected %h, actual %h",
                     $time, pending_estimates[0], rsp_tdata);
            mismatches++;
            void'(pending_estimates.pop_front());
         end else begin
            void'(pending_estimates.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_CAP) begin
         $display("scalar_kalman_filter_top regression: fail");
         $finish;
      end
   end

   // receiver: random stalls, one long hold-off while the sender keeps offering
   initial begin
      int  stall_left;
      int  hold_left;
      bit  hold_done;
      stall_left = 0;
      hold_left  = 0;
      hold_done  = 1'b0;
      rsp_tready <= 1'b0;
      forever begin
         @(negedge clock);
         if (!hold_done && results_seen >= 300) begin
            hold_left = LONG_HOLD;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (burst_mode) begin
            rsp_tready <= 1'b1;
         end else begin
            if (stall_left == 0 && $urandom_range(0, 99) < 25) stall_left = idle_cycles();
            if (stall_left > 0) begin
               stall_left--;
               rsp_tready <= 1'b0;
            end else begin
               rsp_tready <= 1'b1;
            end
         end
      end
   end

   initial begin
      logic [30:0] pn_next;
      logic [30:0] mn_next;
      logic        op;
      logic [31:0] sample;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= skf_pkg::OP_MEASURE;
      csr_we     <= 1'b0;
      csr_index  <= skf_pkg::REG_PROCESS_NOISE;
      csr_wdata  <= '0;
      mismatches   = 0;
      results_seen = 0;
      cycles       = 0;
      burst_mode   = 1'b0;
      est_q = '0;
      var_q = 32'(ONE);
      pn_q  = skf_pkg::PROCESS_NOISE_RESET;
      mn_q  = skf_pkg::MEASUREMENT_NOISE_RESET;

      dir_rows = '{
         '{ROW_WORD, skf_pkg::OP_MEASURE, 32'h0000_0000, 1'b1, 32'h0000_0000},
         '{ROW_WORD, skf_pkg::OP_REINIT,  32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF},
         '{ROW_WORD, skf_pkg::OP_MEASURE, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF},
         '{ROW_WORD, skf_pkg::OP_MEASURE, 32'h8000_0000, 1'b0, 32'h0},
         '{ROW_WORD, skf_pkg::OP_REINIT,  32'h8000_0000, 1'b1, 32'h8000_0000},
         '{ROW_WORD, skf_pkg::OP_MEASURE, 32'h8000_0000, 1'b1, 32'h8000_0000},
         '{ROW_WORD, skf_pkg::OP_MEASURE, 32'h7FFF_FFFF, 1'b0, 32'h0},
         '{ROW_WORD, skf_pkg::OP_REINIT,  32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
         '{ROW_WORD, skf_pkg::OP_MEASURE, 32'h0000_0001, 1'b0, 32'h0},
         '{ROW_WORD, skf_pkg::OP_REINIT,  32'h0001_0000, 1'b1, 32'h0001_0000},
         '{ROW_WORD, skf_pkg::OP_MEASURE, 32'h0002_0000, 1'b0, 32'h0},
         // no noise: gain is 1.0, then the denominator goes to zero
         '{ROW_CSR,  skf_pkg::REG_PROCESS_NOISE,     32'h0, 1'b0, 32'h0},
         '{ROW_CSR,  skf_pkg::REG_MEASUREMENT_NOISE, 32'h0, 1'b0, 32'h0},
         '{ROW_WORD, skf_pkg::OP_MEASURE, 32'h1234_5678, 1'b1, 32'h1234_5678},
         '{ROW_WORD, skf_pkg::OP_MEASURE, 32'h8000_0000, 1'b1, 32'h8000_0000},
         '{ROW_WORD, skf_pkg::OP_MEASURE, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF},
         '{ROW_WORD, skf_pkg::OP_REINIT,  32'hDEAD_BEEF, 1'b1, 32'hDEAD_BEEF},
         '{ROW_WORD, skf_pkg::OP_MEASURE, 32'h5A5A_5A5A, 1'b1, 32'h5A5A_5A5A},
         '{ROW_CSR,  skf_pkg::REG_PROCESS_NOISE,     32'h7FFF_FFFF, 1'b0, 32'h0},
         '{ROW_CSR,  skf_pkg::REG_MEASUREMENT_NOISE, 32'h7FFF_FFFF, 1'b0, 32'h0},
         '{ROW_WORD, skf_pkg::OP_MEASURE, 32'h7FFF_FFFF, 1'b0, 32'h0},
         '{ROW_WORD, skf_pkg::OP_MEASURE, 32'h8000_0000, 1'b0, 32'h0},
         '{ROW_WORD, skf_pkg::OP_MEASURE, 32'h4000_0000, 1'b0, 32'h0},
         '{ROW_CSR,  skf_pkg::REG_PROCESS_NOISE,     32'h0, 1'b0, 32'h0},
         '{ROW_WORD, skf_pkg::OP_REINIT,  32'h0000_0000, 1'b1, 32'h0000_0000},
         '{ROW_WORD, skf_pkg::OP_MEASURE, 32'h7FFF_FFFF, 1'b0, 32'h0},
         '{ROW_CSR,  skf_pkg::REG_PROCESS_NOISE,
           32'(skf_pkg::PROCESS_NOISE_RESET), 1'b0, 32'h0},
         '{ROW_CSR,  skf_pkg::REG_MEASUREMENT_NOISE,
           32'(skf_pkg::MEASUREMENT_NOISE_RESET), 1'b0, 32'h0},
         '{ROW_WORD, skf_pkg::OP_MEASURE, 32'hFFFF_0000, 1'b0, 32'h0}
      };

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         if (dir_rows[i].kind == ROW_CSR) begin
            wait_idle();
            write_reg(dir_rows[i].sel, dir_rows[i].value[30:0]);
         end else begin
            send_word(dir_rows[i].sel, dir_rows[i].value,
                      dir_rows[i].known, dir_rows[i].known_value);
         end
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: begin
               pn_next = skf_pkg::PROCESS_NOISE_RESET;
               mn_next = skf_pkg::MEASUREMENT_NOISE_RESET;
            end
            1: begin pn_next = '0; mn_next = '0; end
            2: begin pn_next = NOISE_MAX; mn_next = NOISE_MAX; end
            3: begin
               pn_next = 31'($urandom_range(0, 32'h1_0000));
               mn_next = 31'($urandom_range(0, 32'h10_0000));
            end
            4: begin pn_next = NOISE_MAX; mn_next = '0; end
            5: begin
               pn_next = 31'($urandom());
               mn_next = 31'($urandom_range(0, 32'h4_0000));
            end
            default: begin pn_next = '0; mn_next = NOISE_MAX; end
         endcase
         wait_idle();
         write_reg(skf_pkg::REG_PROCESS_NOISE, pn_next);
         write_reg(skf_pkg::REG_MEASUREMENT_NOISE, mn_next);
         burst_mode = (ph == 2 || ph == 5);
         for (int n = 0; n < PHASE_LEN; n++) begin
            op = ($urandom_range(0, 7) == 0) ? skf_pkg::OP_REINIT : skf_pkg::OP_MEASURE;
            case ($urandom_range(0, 9))
               0, 1, 2, 3: sample = $urandom();
               4, 5, 6:    sample = est_q + ($urandom_range(0, 32'h7_FFFF) - 32'h4_0000);
               7:          sample = 32'h7FFF_FFFF;
               8:          sample = 32'h8000_0000;
               default:    sample = $urandom_range(0, 32'h1_FFFF) - 32'h1_0000;
            endcase
            send_word(op, sample, 1'b0, '0);
         end
      end
      burst_mode = 1'b0;

      wait_idle();
      repeat (30) @(posedge clock);
      if (mismatches == 0) begin
         $display("scalar_kalman_filter_top regression: pass");
      end else begin
         $display("scalar_kalman_filter_top regression: fail");
      end
      $finish;
   end

endmodule
